// ----- rtl/core/u8u16_pkg.sv -----
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// Used by the front, back and top-level modules; depends on nothing.
package u8u16_pkg;

  // Result status codes.
  localparam logic [1:0] ST_UNIT  = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  // Code unit value of a byte order mark.
  localparam logic [15:0] BOM_UNIT = 16'hFEFF;

  // Depth of each short queue, and the width of its fill count.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Byte classes found by the front part.
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_CONT  = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_UNSUP = 3'd4,
    CLS_BAD   = 3'd5
  } byte_class_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
  } item_t;

  // One result request on its way out.
  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  status;
    logic        eos;
  } result_t;

  // Classify a raw byte by its lead bits.
  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if (b == 8'h00) begin
      c = CLS_BAD;
    end else if (b[7] == 1'b0) begin
      c = CLS_ASCII;
    end else if (b[7:6] == 2'b10) begin
      c = CLS_CONT;
    end else if (b[7:5] == 3'b110) begin
      c = CLS_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      c = CLS_LEAD3;
    end else if (b[7:1] == 7'b1111111) begin
      c = CLS_BAD;
    end else begin
      c = CLS_UNSUP;
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/u8u16_front.sv -----
// Front part: takes raw bytes, classifies them and holds them in a short queue.
// Depends on u8u16_pkg.
module u8u16_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        byte_in,
  input  logic              last_byte,
  output logic              item_valid,
  input  logic              item_take,
  output u8u16_pkg::item_t  item
);

  u8u16_pkg::item_t                     slot_r [u8u16_pkg::QUEUE_DEPTH];
  logic [u8u16_pkg::PTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [u8u16_pkg::PTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [u8u16_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                                 do_push, do_pop;

  // Queue handshake; full is a register-only decode so the two sides stay apart.
  assign full       = (cnt_r == u8u16_pkg::CNT_W'(u8u16_pkg::QUEUE_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;
  assign item       = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == u8u16_pkg::PTR_W'(u8u16_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == u8u16_pkg::PTR_W'(u8u16_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Classified byte storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= '{data: byte_in, last: last_byte,
                            cls: u8u16_pkg::classify(byte_in)};
    end
  end

endmodule

// ----- rtl/core/u8u16_back.sv -----
// Back part: runs the sequence decoder on classified bytes and queues the results.
// Depends on u8u16_pkg.
module u8u16_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_take,
  input  u8u16_pkg::item_t  item,
  output logic              empty,
  input  logic              pop,
  output u8u16_pkg::result_t result
);

  // Decoder state.
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] part_r, part_nxt;
  logic [1:0]  seq_r, seq_nxt;
  logic        start_r, start_nxt;
  logic        disc_r, disc_nxt;

  // Result queue.
  u8u16_pkg::result_t               slot_r [u8u16_pkg::QUEUE_DEPTH];
  logic [u8u16_pkg::PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [u8u16_pkg::PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [u8u16_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;

  logic               res_valid;
  u8u16_pkg::result_t res;
  logic [15:0]        shifted;
  logic [1:0]         pend_dec;
  logic               do_pop, do_push;

  assign empty    = (cnt_r == '0);
  assign do_pop   = pop && !empty;
  assign result   = slot_r[rd_ptr_r];
  // An item is taken whenever the result queue has room for its result.
  assign item_take = item_valid &&
                     ((cnt_r != u8u16_pkg::CNT_W'(u8u16_pkg::QUEUE_DEPTH)) || do_pop);
  assign do_push  = item_take && res_valid;

  assign shifted  = {part_r[9:0], item.data[5:0]};
  assign pend_dec = pend_r - 2'd1;

  // Sequence decoder: one classified byte per cycle while the result queue has room.
  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    seq_nxt   = seq_r;
    start_nxt = start_r;
    disc_nxt  = disc_r;
    res_valid = 1'b0;
    res       = '{unit: 16'h0000, status: u8u16_pkg::ST_BAD, eos: item.last};
    if (item_take) begin
      if (disc_r) begin
        // Dropping the rest of a string after an error.
        if (item.last) begin
          res_valid = 1'b1;
          res.status = u8u16_pkg::ST_END;
          disc_nxt  = 1'b0;
          start_nxt = 1'b1;
        end
      end else if (pend_r != 2'd0) begin
        if (item.cls != u8u16_pkg::CLS_CONT) begin
          res_valid = 1'b1;
        end else if (pend_dec != 2'd0) begin
          if (item.last) begin
            res_valid = 1'b1;
          end else begin
            part_nxt = shifted;
            pend_nxt = pend_dec;
          end
        end else begin
          // Sequence complete; a leading byte order mark gives no code unit.
          part_nxt  = 16'h0000;
          seq_nxt   = 2'd0;
          pend_nxt  = 2'd0;
          start_nxt = item.last;
          if (start_r && (seq_r == 2'd3) && (shifted == u8u16_pkg::BOM_UNIT)) begin
            res_valid  = item.last;
            res.status = u8u16_pkg::ST_END;
          end else begin
            res_valid  = 1'b1;
            res.unit   = shifted;
            res.status = u8u16_pkg::ST_UNIT;
          end
        end
      end else begin
        unique case (item.cls)
          u8u16_pkg::CLS_ASCII: begin
            res_valid  = 1'b1;
            res.unit   = {8'h00, item.data};
            res.status = u8u16_pkg::ST_UNIT;
            start_nxt  = item.last;
          end
          u8u16_pkg::CLS_LEAD2: begin
            if (item.last) begin
              res_valid = 1'b1;
            end else begin
              part_nxt = {11'h000, item.data[4:0]};
              seq_nxt  = 2'd2;
              pend_nxt = 2'd1;
            end
          end
          u8u16_pkg::CLS_LEAD3: begin
            if (item.last) begin
              res_valid = 1'b1;
            end else begin
              part_nxt = {12'h000, item.data[3:0]};
              seq_nxt  = 2'd3;
              pend_nxt = 2'd2;
            end
          end
          u8u16_pkg::CLS_UNSUP: begin
            res_valid  = 1'b1;
            res.status = u8u16_pkg::ST_UNSUP;
          end
          default: begin
            res_valid = 1'b1;
          end
        endcase
      end
      // Any error result drops the rest of the string, or ends it here.
      if (res_valid && ((res.status == u8u16_pkg::ST_BAD) ||
                        (res.status == u8u16_pkg::ST_UNSUP))) begin
        pend_nxt  = 2'd0;
        part_nxt  = 16'h0000;
        seq_nxt   = 2'd0;
        start_nxt = item.last;
        disc_nxt  = !item.last;
      end
    end
  end

  // Result queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == u8u16_pkg::PTR_W'(u8u16_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == u8u16_pkg::PTR_W'(u8u16_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 2'd0;
      part_r   <= 16'h0000;
      seq_r    <= 2'd0;
      start_r  <= 1'b1;
      disc_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      pend_r   <= pend_nxt;
      part_r   <= part_nxt;
      seq_r    <= seq_nxt;
      start_r  <= start_nxt;
      disc_r   <= disc_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ----- rtl/core/utf8_to_utf16_decoder.sv -----
// Path: each accepted byte is registered in the byte queue, and the result it completes in the result queue.
// Throughput: one byte per cycle while the result queue has room, set by the sequence decoder in the back part.
// Two-entry queues after the classifier and after the decoder absorb stalls on either side.
// Reset: synchronous, active low; both queues empty and the decoder at string start.
// Top level of the UTF-8 to UTF-16 decoder; depends on u8u16_pkg, u8u16_front, u8u16_back.
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_code_unit,
  output logic [1:0]  out_status,
  output logic        out_end_of_string
);

  u8u16_pkg::item_t   item;
  u8u16_pkg::result_t result;
  logic               item_valid;
  logic               item_take;

  // Classifier and byte queue.
  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .byte_in    (in_byte_in),
    .last_byte  (in_last_byte),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  // Decoder and result queue.
  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  assign out_code_unit     = result.unit;
  assign out_status        = result.status;
  assign out_end_of_string = result.eos;

endmodule

// ----- rtl/core/u8u16_checker.sv -----
// Port-level checks of the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on u8u16_pkg and utf8_to_utf16_decoder.
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] out_code_unit,
  input logic [1:0]  out_status,
  input logic        out_end_of_string
);

  // Reset leaves the result queue empty and the byte queue not full.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // A waiting result stays until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result dropped before pop");

  // An end-only result always closes a string.
  a_end_marks_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == u8u16_pkg::ST_END)) |-> out_end_of_string)
    else $error("end marker without end of string");

  // Error and end results carry no code unit.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status != u8u16_pkg::ST_UNIT)) |-> (out_code_unit == 16'h0000))
    else $error("code unit on a non-unit result");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_code_unit     (out_code_unit),
  .out_status        (out_status),
  .out_end_of_string (out_end_of_string)
);
